/* rtl/glp_pkg.sv */
// Shared types and constants for the gated record/loop player.
// No dependencies; used by every module of the block.

package glp_pkg;

	// default sizing
	localparam int DEPTH_DEF     = 65536;
	localparam int FRAC_BITS_DEF = 16;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int GATE_W   = 15;
	localparam int RATE_W   = 14;
	localparam int LEN_MV_W = 14;
	localparam int PULSE_W  = 16;

	// stream and config port widths
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// scaling divisors: step = rate_mv / 5000, length = (depth-1) * mv / 10000
	localparam int RATE_DIV    = 5000;
	localparam int LEN_DIV     = 10000;
	// extra fraction bits kept in the reciprocal constants
	localparam int RECIP_SHIFT = 16;

	// config reset values
	localparam logic [PULSE_W-1:0]       PULSE_SAMPLES_RST = 16'd48;
	localparam logic signed [GATE_W-1:0] GATE_HIGH_RST     = 15'sd1000;
	localparam logic signed [GATE_W-1:0] GATE_LOW_RST      = 15'sd0;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PULSE_SAMPLES = 2'd0,
		CFG_GATE_HIGH_MV  = 2'd1,
		CFG_GATE_LOW_MV   = 2'd2
	} cfg_idx_t;

	// live config values
	typedef struct packed {
		logic [PULSE_W-1:0]       pulse_samples;
		logic signed [GATE_W-1:0] gate_high;
		logic signed [GATE_W-1:0] gate_low;
	} cfg_t;

	// per-request payload carried down the pipe
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [GATE_W-1:0]   gate;
	} item_t;

	// per-request result status leaving the loop stage
	typedef struct packed {
		logic                rec;
		logic                trig;
		logic                rd_ok;
		logic [SAMPLE_W-1:0] sample;
	} res_t;

endpackage

/* rtl/gated_record_loop_player.sv */
// Top level of the gated record/loop player: ports, config registers, flow control.
// Depends on glp_pkg, glp_scale, glp_loop, glp_ram.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tdata: sample_in, gate_mv, rate_mv, length_mv
//  m_*       out  tvalid/tready     tdata: sample_out, trig_out
//  cfg_*     in   cfg_wr_en         cfg_index, cfg_wdata
//
// One request per cycle sustained while m_tready is high; s_tdata reaches m_tdata through
// four scaling stages, then the loop stage and the memory read register.
// The loop stage updates position, gate, pulse and (when recording) head once per
// request and makes one memory access: a write when recording, a read when playing.
// Reset is immediate: no clearing pass, unwritten entries read as zero.
// A held result stalls the whole pipe; s_tready = !res_valid || m_tready.

module gated_record_loop_player #(
	parameter int DEPTH     = glp_pkg::DEPTH_DEF,
	parameter int FRAC_BITS = glp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// [15:0] sample_in, [30:16] gate_mv, [44:31] rate_mv, [58:45] length_mv
	input  logic [glp_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] sample_out, [16] trig_out
	output logic [glp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               cfg_wr_en,
	input  logic [glp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [glp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int A = $clog2(DEPTH);

	glp_pkg::cfg_t                   cfg_q;
	logic                            adv;
	glp_pkg::item_t                  in_item;
	logic                            sc_valid;
	glp_pkg::item_t                  sc_item;
	logic [FRAC_BITS+1:0]            sc_step;
	logic [A-1:0]                    sc_len;
	logic [A-1:0]                    sc_dhi;
	logic                            ram_we;
	logic                            ram_re;
	logic [A-1:0]                    ram_addr;
	logic [glp_pkg::SAMPLE_W-1:0]    ram_wdata;
	logic [glp_pkg::SAMPLE_W-1:0]    ram_rdata;
	logic                            res_valid;
	glp_pkg::res_t                   res;
	logic [glp_pkg::SAMPLE_W-1:0]    sample_out;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_samples <= glp_pkg::PULSE_SAMPLES_RST;
			cfg_q.gate_high     <= glp_pkg::GATE_HIGH_RST;
			cfg_q.gate_low      <= glp_pkg::GATE_LOW_RST;
		end else if (cfg_wr_en) begin
			case (glp_pkg::cfg_idx_t'(cfg_index))
				glp_pkg::CFG_PULSE_SAMPLES: begin
					cfg_q.pulse_samples <= cfg_wdata;
				end
				glp_pkg::CFG_GATE_HIGH_MV: begin
					cfg_q.gate_high <= cfg_wdata[glp_pkg::GATE_W-1:0];
				end
				glp_pkg::CFG_GATE_LOW_MV: begin
					cfg_q.gate_low <= cfg_wdata[glp_pkg::GATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// whole pipe moves unless a result is held
	assign adv      = !res_valid || m_tready;
	assign s_tready = adv;

	// unpack the input request
	assign in_item.sample = s_tdata[15:0];
	assign in_item.gate   = s_tdata[30:16];

	glp_scale #(
		.DEPTH     (DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.in_item   (in_item),
		.in_rate   (s_tdata[44:31]),
		.in_len_mv (s_tdata[58:45]),
		.out_valid (sc_valid),
		.out_item  (sc_item),
		.out_step  (sc_step),
		.out_len   (sc_len),
		.out_dhi   (sc_dhi)
	);

	glp_loop #(
		.DEPTH     (DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_loop (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (sc_valid),
		.in_item   (sc_item),
		.in_step   (sc_step),
		.in_len    (sc_len),
		.in_dhi    (sc_dhi),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.out_valid (res_valid),
		.out_res   (res)
	);

	glp_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// pass-through when recording, memory data (or zero if unwritten) when playing
	always_comb begin
		if (res.rec) begin
			sample_out = res.sample;
		end else if (res.rd_ok) begin
			sample_out = ram_rdata;
		end else begin
			sample_out = '0;
		end
	end

	assign m_tvalid = res_valid;
	assign m_tdata  = {7'b0, res.trig, sample_out};

endmodule

/* rtl/glp_scale.sv */
// Pipelined scaling of rate and length controls (stages s1..s4).
// Constant divisions done by reciprocal multiply plus one correction step.
// Depends on glp_pkg.

module glp_scale #(
	parameter int DEPTH     = glp_pkg::DEPTH_DEF,
	parameter int FRAC_BITS = glp_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  glp_pkg::item_t                  in_item,
	input  logic [glp_pkg::RATE_W-1:0]      in_rate,
	input  logic [glp_pkg::LEN_MV_W-1:0]    in_len_mv,
	output logic                            out_valid,
	output glp_pkg::item_t                  out_item,
	output logic [FRAC_BITS+1:0]            out_step,
	output logic [$clog2(DEPTH)-1:0]        out_len,
	output logic [$clog2(DEPTH)-1:0]        out_dhi
);

	localparam int A       = $clog2(DEPTH);
	localparam int STEP_W  = FRAC_BITS + 2;
	localparam int SR_W    = FRAC_BITS + 4;
	localparam int RPROD_W = glp_pkg::RATE_W + SR_W;
	localparam int NUM_W   = FRAC_BITS + 15;
	localparam int LR_W    = A + 3;
	localparam int LPROD_W = glp_pkg::LEN_MV_W + LR_W;
	localparam int QL_W    = A + 1;
	localparam int LNUM_W  = A + 15;

	localparam logic [63:0] STEP_RECIP =
		(64'd1 << (FRAC_BITS + glp_pkg::RECIP_SHIFT)) / 64'(glp_pkg::RATE_DIV);
	localparam logic [63:0] LEN_RECIP =
		(64'(DEPTH - 1) << glp_pkg::RECIP_SHIFT) / 64'(glp_pkg::LEN_DIV);

	localparam logic [NUM_W-1:0]  RDIV = NUM_W'(glp_pkg::RATE_DIV);
	localparam logic [LNUM_W-1:0] LDIV = LNUM_W'(glp_pkg::LEN_DIV);
	localparam logic [QL_W-1:0]   LMAX = QL_W'(DEPTH - 1);
	localparam logic [A-1:0]      AMAX = A'(DEPTH - 1);

	// s1: reciprocal products
	logic                         v_s1;
	glp_pkg::item_t               item_s1;
	logic [glp_pkg::RATE_W-1:0]   rate_s1;
	logic [RPROD_W-1:0]           rprod_s1;
	logic [LPROD_W-1:0]           lprod_s1;
	logic [LNUM_W-1:0]            lexact_s1;

	// s2: estimates and back-products
	logic                         v_s2;
	glp_pkg::item_t               item_s2;
	logic [NUM_W-1:0]             rnum_s2;
	logic [STEP_W-1:0]            qs_s2;
	logic [NUM_W-1:0]             qsprod_s2;
	logic [QL_W-1:0]              ql_s2;
	logic [LNUM_W-1:0]            qlprod_s2;
	logic [LNUM_W-1:0]            lexact_s2;

	// s3: corrected quotients
	logic                         v_s3;
	glp_pkg::item_t               item_s3;
	logic [STEP_W-1:0]            step_s3;
	logic [QL_W-1:0]              len_s3;

	// s4: saturated length and jump distance
	logic                         v_s4;
	glp_pkg::item_t               item_s4;
	logic [STEP_W-1:0]            step_s4;
	logic [A-1:0]                 len_s4;
	logic [A-1:0]                 dhi_s4;

	logic [STEP_W-1:0]            qs_d;
	logic [QL_W-1:0]              ql_d;
	logic [NUM_W-1:0]             rrem_d;
	logic [LNUM_W-1:0]            lrem_d;
	logic [A-1:0]                 len_sat_d;

	// estimates drop the reciprocal fraction bits
	assign qs_d = rprod_s1[glp_pkg::RECIP_SHIFT +: STEP_W];
	assign ql_d = lprod_s1[glp_pkg::RECIP_SHIFT +: QL_W];

	// remainders against the estimates
	assign rrem_d = rnum_s2 - qsprod_s2;
	assign lrem_d = lexact_s2 - qlprod_s2;

	// length clamps at depth-1
	assign len_sat_d = (len_s3 > LMAX) ? AMAX : len_s3[A-1:0];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1   <= in_item;
			rate_s1   <= in_rate;
			rprod_s1  <= RPROD_W'(in_rate) * RPROD_W'(STEP_RECIP);
			lprod_s1  <= LPROD_W'(in_len_mv) * LPROD_W'(LEN_RECIP);
			lexact_s1 <= LNUM_W'(in_len_mv) * LNUM_W'(DEPTH - 1);

			item_s2   <= item_s1;
			rnum_s2   <= NUM_W'(rate_s1) << FRAC_BITS;
			qs_s2     <= qs_d;
			qsprod_s2 <= NUM_W'(qs_d) * RDIV;
			ql_s2     <= ql_d;
			qlprod_s2 <= LNUM_W'(ql_d) * LDIV;
			lexact_s2 <= lexact_s1;

			item_s3   <= item_s2;
			step_s3   <= qs_s2 + STEP_W'(rrem_d >= RDIV);
			len_s3    <= ql_s2 + QL_W'(lrem_d >= LDIV);

			item_s4   <= item_s3;
			step_s4   <= step_s3;
			len_s4    <= len_sat_d;
			dhi_s4    <= AMAX - len_sat_d;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;
	assign out_step  = step_s4;
	assign out_len   = len_s4;
	assign out_dhi   = dhi_s4;

endmodule

/* rtl/glp_ram.sv */
// Single-port sample memory with registered read data.
// No dependencies beyond glp_pkg widths.

module glp_ram #(
	parameter int DEPTH = glp_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         addr,
	input  logic [glp_pkg::SAMPLE_W-1:0]     wdata,
	output logic [glp_pkg::SAMPLE_W-1:0]     rdata
);

	logic [glp_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [glp_pkg::SAMPLE_W-1:0] rd_data_q;

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rdata = rd_data_q;

endmodule

/* rtl/glp_loop.sv */
// Loop stage: gate trigger, write head, play position, pulse counter.
// Drives the sample memory and holds the s5 result register.
// Depends on glp_pkg.

module glp_loop #(
	parameter int DEPTH     = glp_pkg::DEPTH_DEF,
	parameter int FRAC_BITS = glp_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  glp_pkg::cfg_t                    cfg,
	input  logic                             in_valid,
	input  glp_pkg::item_t                   in_item,
	input  logic [FRAC_BITS+1:0]             in_step,
	input  logic [$clog2(DEPTH)-1:0]         in_len,
	input  logic [$clog2(DEPTH)-1:0]         in_dhi,
	output logic                             ram_we,
	output logic                             ram_re,
	output logic [$clog2(DEPTH)-1:0]         ram_addr,
	output logic [glp_pkg::SAMPLE_W-1:0]     ram_wdata,
	output logic                             out_valid,
	output glp_pkg::res_t                    out_res
);

	localparam int A   = $clog2(DEPTH);
	localparam int P_W = A + FRAC_BITS;
	localparam int W   = P_W + 2;

	localparam logic [W-1:0]     SPAN  = W'(DEPTH) << FRAC_BITS;
	localparam logic [P_W:0]     HALF  = (P_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [A:0]       DEPTH_X = (A + 1)'(DEPTH);
	localparam logic [A-1:0]     AMAX  = A'(DEPTH - 1);

	// loop state
	logic [A-1:0]                head_q;
	logic [P_W-1:0]              pos_q;
	logic                        gate_on_q;
	logic [glp_pkg::PULSE_W-1:0] pulse_q;
	logic                        wrapped_q;

	// result register
	logic                        v_s5;
	glp_pkg::res_t               res_s5;

	logic                        gate_on_n;
	logic                        fire;
	logic [W-1:0]                pos_w;
	logic [W-1:0]                next_w;
	logic [W-1:0]                head_fx;
	logic                        crossed;
	logic [W-1:0]                jump_w;
	logic [W-1:0]                moved_w;
	logic [P_W-1:0]              pos_play;
	logic [P_W:0]                rnd;
	logic [A:0]                  idx_full;
	logic [A-1:0]                idx;
	logic                        rd_ok;
	logic [A-1:0]                head_inc;
	logic                        head_last;
	logic [glp_pkg::PULSE_W-1:0] pulse_mid;
	logic                        trig;

	assign fire = adv && in_valid;

	// Schmitt trigger on the gate
	always_comb begin
		if (gate_on_q) begin
			gate_on_n = !($signed(in_item.gate) <= $signed(cfg.gate_low));
		end else begin
			gate_on_n = ($signed(in_item.gate) >= $signed(cfg.gate_high));
		end
	end

	// play position advance and loop-back
	assign pos_w   = W'(pos_q);
	assign next_w  = pos_w + W'(in_step);
	assign head_fx = W'(head_q) << FRAC_BITS;
	assign crossed = (next_w > head_fx) && (pos_w <= head_fx);
	// tail minus head is depth-1-length or -length, head cancels out
	assign jump_w  = (in_len > head_q) ? (next_w + (W'(in_dhi) << FRAC_BITS))
	                                   : (next_w - (W'(in_len) << FRAC_BITS));
	assign moved_w = crossed ? jump_w : next_w;
	always_comb begin
		if (moved_w >= SPAN) begin
			pos_play = P_W'(moved_w - SPAN);
		end else begin
			pos_play = moved_w[P_W-1:0];
		end
	end

	// rounded read index, wrapped at depth
	assign rnd      = (P_W + 1)'(pos_q) + HALF;
	assign idx_full = rnd[P_W:FRAC_BITS];
	assign idx      = (idx_full == DEPTH_X) ? '0 : idx_full[A-1:0];
	// unwritten entries read as zero until the head has wrapped once
	assign rd_ok    = wrapped_q || (idx < head_q);

	// write head advance
	assign head_last = (head_q == AMAX);
	assign head_inc  = head_last ? '0 : (head_q + A'(1));

	// trigger pulse
	always_comb begin
		pulse_mid = pulse_q;
		if (gate_on_n && crossed && (pulse_q < cfg.pulse_samples)) begin
			pulse_mid = cfg.pulse_samples;
		end
	end
	assign trig = (pulse_mid != '0);

	// memory request
	assign ram_we    = fire && !gate_on_n;
	assign ram_re    = fire && gate_on_n;
	assign ram_addr  = gate_on_n ? idx : head_q;
	assign ram_wdata = in_item.sample;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			pos_q     <= '0;
			gate_on_q <= 1'b0;
			pulse_q   <= '0;
			wrapped_q <= 1'b0;
			v_s5      <= 1'b0;
		end else begin
			if (adv) begin
				v_s5 <= in_valid;
			end
			if (fire) begin
				gate_on_q <= gate_on_n;
				pulse_q   <= trig ? (pulse_mid - glp_pkg::PULSE_W'(1)) : '0;
				if (gate_on_n) begin
					pos_q <= pos_play;
				end else begin
					head_q <= head_inc;
					pos_q  <= {head_inc, {FRAC_BITS{1'b0}}};
					if (head_last) begin
						wrapped_q <= 1'b1;
					end
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5.rec    <= !gate_on_n;
			res_s5.trig   <= trig;
			res_s5.rd_ok  <= rd_ok;
			res_s5.sample <= in_item.sample;
		end
	end

	assign out_valid = v_s5;
	assign out_res   = res_s5;

`ifndef SYNTHESIS
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AMAX)
		else $error("write head beyond depth");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		W'(pos_q) < SPAN)
		else $error("play position beyond span");

	a_rec_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !gate_on_n) |=> (pos_q == {head_q, {FRAC_BITS{1'b0}}}))
		else $error("record did not park play position at head");

	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wrapped_q) |-> (head_q == '0))
		else $error("fill wrap flag set away from head zero");

	a_gate_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		(gate_on_q != $past(gate_on_q)) |-> $past(fire))
		else $error("gate state changed without a request");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for gated_record_loop_player: directed table, then random record/play
// bursts over several gate and pulse settings; checks use the table or a local predictor.
// Depends on glp_pkg and the gated_record_loop_player RTL.

module testbench;

	localparam int MEM_DEPTH   = glp_pkg::DEPTH_DEF;
	localparam int FRAC        = glp_pkg::FRAC_BITS_DEF;
	localparam int HEAD_W      = $clog2(MEM_DEPTH);
	localparam int POS_W       = HEAD_W + FRAC;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 130;
	localparam int HOLD_CYCLES = 250;
	localparam int DIR_N       = 17;
	localparam int N_SETTINGS  = 6;

	typedef struct packed {
		logic signed [glp_pkg::SAMPLE_W-1:0] sample;
		logic signed [glp_pkg::GATE_W-1:0]   gate;
		logic [glp_pkg::RATE_W-1:0]          rate;
		logic [glp_pkg::LEN_MV_W-1:0]        len_mv;
	} loop_req_t;

	typedef struct packed {
		logic [glp_pkg::SAMPLE_W-1:0] sample;
		logic                         trig;
	} loop_res_t;

	typedef struct packed {
		loop_req_t req;
		logic      typed;
		loop_res_t res;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n;
	// [15:0] sample_in, [30:16] gate_mv, [44:31] rate_mv, [58:45] length_mv
	logic [glp_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            s_tvalid;
	logic                            s_tready;
	// [15:0] sample_out, [16] trig_out
	logic [glp_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic                            cfg_wr_en;
	logic [glp_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [glp_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	// predictor state and live settings
	logic [glp_pkg::SAMPLE_W-1:0]    rec_mem [MEM_DEPTH];
	logic [HEAD_W-1:0]               rec_head;
	logic [POS_W-1:0]                play_pos;
	logic                            gate_on_q;
	logic [glp_pkg::PULSE_W-1:0]     pulse_left_q;
	glp_pkg::cfg_t                   live_cfg;

	loop_res_t                       expected_audio [$];
	dir_row_t                        dir_rows [DIR_N];
	glp_pkg::cfg_t                   settings [N_SETTINGS];
	bit                              had_error;
	bit                              no_idle;
	bit                              hold_req;
	int                              items_sent;
	int                              cycles;

	gated_record_loop_player dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// advance the predictor by one request and return the result it should produce
	function automatic loop_res_t predict_loop_output(loop_req_t rq);
		longint unsigned step, loop_len, head, tail, pos, idx, head_fx, nxt;
		loop_res_t res;
		step     = (64'(rq.rate) << FRAC) / glp_pkg::RATE_DIV;
		loop_len = (64'(MEM_DEPTH - 1) * 64'(rq.len_mv)) / glp_pkg::LEN_DIV;
		if (loop_len > 64'(MEM_DEPTH - 1))
			loop_len = 64'(MEM_DEPTH - 1);
		head = 64'(rec_head);
		if (loop_len > head)
			tail = 64'(MEM_DEPTH - 1) - (loop_len - head);
		else
			tail = head - loop_len;

		// Schmitt trigger on the gate
		if (gate_on_q) begin
			if ($signed(rq.gate) <= $signed(live_cfg.gate_low))
				gate_on_q = 1'b0;
		end else if ($signed(rq.gate) >= $signed(live_cfg.gate_high)) begin
			gate_on_q = 1'b1;
		end

		if (gate_on_q) begin
			pos     = 64'(play_pos);
			idx     = ((pos + (64'd1 << (FRAC - 1))) >> FRAC) % 64'(MEM_DEPTH);
			head_fx = head << FRAC;
			nxt     = pos + step;
			res.sample = rec_mem[idx];
			// crossing the head: jump back to the tail, keep the overshoot
			if (nxt > head_fx && pos <= head_fx) begin
				nxt = (tail << FRAC) + (nxt - head_fx);
				if (pulse_left_q < live_cfg.pulse_samples)
					pulse_left_q = live_cfg.pulse_samples;
			end
			play_pos = POS_W'(nxt);
		end else begin
			rec_mem[rec_head] = rq.sample;
			res.sample = rq.sample;
			rec_head   = rec_head + 1'b1;
			play_pos   = POS_W'(rec_head) << FRAC;
		end

		res.trig = (pulse_left_q != '0);
		if (res.trig)
			pulse_left_q = pulse_left_q - 1'b1;
		return res;
	endfunction

	// gate value that turns the gate on (or off) under the live thresholds, best effort
	function automatic logic signed [glp_pkg::GATE_W-1:0] pick_gate(bit want_on);
		int hi_mv, lo_mv, bound, lo, hi;
		hi_mv = $signed(live_cfg.gate_high);
		lo_mv = $signed(live_cfg.gate_low);
		if (want_on) begin
			bound = (hi_mv > lo_mv + 1) ? hi_mv : lo_mv + 1;
			if (bound > 16383)
				bound = 16383;
			lo = bound;
			hi = (bound <= 12000) ? 12000 : 16383;
		end else begin
			bound = (lo_mv < hi_mv - 1) ? lo_mv : hi_mv - 1;
			if (bound < -16384)
				bound = -16384;
			hi = bound;
			lo = (bound >= -12000) ? -12000 : -16384;
		end
		return glp_pkg::GATE_W'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic logic [glp_pkg::RATE_W-1:0] pick_rate();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return glp_pkg::RATE_W'($urandom_range(0, 50));
		else if (r < 9)
			return glp_pkg::RATE_W'($urandom_range(0, 10000));
		return glp_pkg::RATE_W'($urandom_range(0, 16383));
	endfunction

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// offer one request, wait for acceptance, then queue its expected result
	task automatic send_request(loop_req_t rq, logic typed, loop_res_t typed_res);
		loop_res_t predicted;
		if (!no_idle && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		s_tdata  <= glp_pkg::IN_TDATA_W'({rq.len_mv, rq.rate, rq.gate, rq.sample});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = predict_loop_output(rq);
		expected_audio.push_back(typed ? typed_res : predicted);
		items_sent++;
	endtask

	// one record burst followed by a play burst, or a short burst of raw noise
	task automatic run_sequence();
		loop_req_t                    rq;
		int                           n_rec, n_play, r;
		logic [glp_pkg::RATE_W-1:0]   rate;
		logic [glp_pkg::LEN_MV_W-1:0] len_mv;
		no_idle = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0) begin
			// every field over its whole width
			repeat ($urandom_range(1, 8)) begin
				rq = $bits(loop_req_t)'({$urandom, $urandom});
				send_request(rq, 1'b0, '0);
			end
		end else begin
			rate = pick_rate();
			r = $urandom_range(0, 9);
			if (r < 6)
				len_mv = glp_pkg::LEN_MV_W'($urandom_range(0, 40));
			else if (r < 9)
				len_mv = glp_pkg::LEN_MV_W'($urandom_range(0, 10000));
			else
				len_mv = glp_pkg::LEN_MV_W'($urandom_range(0, 16383));
			n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 400)
			                                   : $urandom_range(1, 40);
			repeat (n_rec) begin
				rq.sample = glp_pkg::SAMPLE_W'($urandom);
				rq.gate   = pick_gate(1'b0);
				rq.rate   = rate;
				rq.len_mv = len_mv;
				send_request(rq, 1'b0, '0);
			end
			n_play = $urandom_range(1, 120);
			repeat (n_play) begin
				if ($urandom_range(0, 15) == 0)
					rate = pick_rate();
				rq.sample = glp_pkg::SAMPLE_W'($urandom);
				if ($urandom_range(0, 19) == 0)
					rq.gate = glp_pkg::GATE_W'(int'($urandom_range(0, 24000)) - 12000);
				else
					rq.gate = pick_gate(1'b1);
				rq.rate   = rate;
				rq.len_mv = len_mv;
				send_request(rq, 1'b0, '0);
			end
		end
	endtask

	// stimulus and phase control
	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		had_error  = 1'b0;
		no_idle    = 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;
		foreach (rec_mem[i])
			rec_mem[i] = '0;
		rec_head     = '0;
		play_pos     = '0;
		gate_on_q    = 1'b0;
		pulse_left_q = '0;
		live_cfg     = '{glp_pkg::PULSE_SAMPLES_RST, glp_pkg::GATE_HIGH_RST,
		                 glp_pkg::GATE_LOW_RST};

		// after reset: pulse 48, on at 1000 mV, off at 0 mV
		dir_rows = '{
			// record the extremes of the sample
			'{'{16'sh8000, -15'sd12000, 14'd0,     14'd0},     1'b1, '{16'h8000, 1'b0}},
			'{'{16'sh7FFF,  15'sd999,   14'd16383, 14'd16383}, 1'b1, '{16'h7FFF, 1'b0}},
			'{'{16'sh1234,  15'sd0,     14'd10000, 14'd0},     1'b1, '{16'h1234, 1'b0}},
			'{'{16'sh5A5A, -15'sd1,     14'd5000,  14'd3},     1'b1, '{16'h5A5A, 1'b0}},
			// on exactly at the high level: plays the unwritten slot at the head, wraps
			'{'{16'shFFFF,  15'sd1000,  14'd5000,  14'd0},     1'b1, '{16'h0000, 1'b1}},
			'{'{16'sh0001,  15'sd1,     14'd5000,  14'd1},     1'b0, '0},
			// zero rate holds the position
			'{'{16'sh0002,  15'sd12000, 14'd0,     14'd0},     1'b0, '0},
			// top of the gate field, rate and length saturation
			'{'{16'sh0003,  15'sh3FFF,  14'd16383, 14'd16383}, 1'b0, '0},
			// off exactly at the low level, pulse still running
			'{'{16'sh00FF,  15'sd0,     14'd1,     14'd2},     1'b1, '{16'h00FF, 1'b1}},
			'{'{16'shFFFF,  15'sh4000,  14'd9999,  14'd9999},  1'b1, '{16'hFFFF, 1'b1}},
			'{'{16'sh4000,  15'sd5000,  14'd2500,  14'd1},     1'b0, '0},
			'{'{16'sh0004,  15'sd5000,  14'd1,     14'd1},     1'b0, '0},
			'{'{16'sh0005,  15'sd5000,  14'd9999,  14'd1},     1'b0, '0},
			'{'{16'sh0006,  15'sd5000,  14'd10000, 14'd10000}, 1'b0, '0},
			// between the levels: stays on
			'{'{16'sh0007,  15'sd500,   14'd5000,  14'd2},     1'b0, '0},
			'{'{16'sh2AAA, -15'sd1,     14'd5000,  14'd2},     1'b1, '{16'h2AAA, 1'b1}},
			// between the levels: stays off
			'{'{16'sh5555,  15'sd500,   14'd5000,  14'd2},     1'b1, '{16'h5555, 1'b1}}
		};

		// pulse length, on level, off level per phase after the reset one
		settings = '{
			'{16'd1,     15'sd2000,  -15'sd2000},
			'{16'd65535, 15'sd12000, -15'sd12000},
			'{16'd0,    -15'sd500,    15'sd500},
			'{16'd200,   15'sh4000,   15'sh4000},
			'{16'd3,     15'sh3FFF,   15'sh3FFF},
			'{16'd48,    15'sd1000,   15'sd0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

		for (int phase = 0; phase <= N_SETTINGS; phase++) begin
			if (phase > 0) begin
				// drain, let the pipe settle, then rewrite all three registers
				s_tvalid <= 1'b0;
				while (expected_audio.size() != 0) @(posedge clk);
				repeat (8) @(posedge clk);
				cfg_wr_en <= 1'b1;
				cfg_index <= glp_pkg::CFG_PULSE_SAMPLES;
				cfg_wdata <= settings[phase-1].pulse_samples;
				@(posedge clk);
				cfg_index <= glp_pkg::CFG_GATE_HIGH_MV;
				cfg_wdata <= {settings[phase-1].gate_high[glp_pkg::GATE_W-1],
				              settings[phase-1].gate_high};
				@(posedge clk);
				cfg_index <= glp_pkg::CFG_GATE_LOW_MV;
				cfg_wdata <= {settings[phase-1].gate_low[glp_pkg::GATE_W-1],
				              settings[phase-1].gate_low};
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				live_cfg = settings[phase-1];
			end
			if (phase == 1 || phase == 4)
				hold_req = 1'b1;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				run_sequence();
		end

		s_tvalid <= 1'b0;
		while (expected_audio.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!had_error)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
				stall = idle_len();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	initial begin
		loop_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_audio.size() == 0) begin
					$error("unexpected result: m_tdata %h", m_tdata);
					had_error = 1'b1;
				end else begin
					want = expected_audio.pop_front();
					if (m_tdata[glp_pkg::SAMPLE_W-1:0] !== want.sample) begin
						$error("sample_out: expected %h, got %h", want.sample,
							m_tdata[glp_pkg::SAMPLE_W-1:0]);
						had_error = 1'b1;
					end
					if (m_tdata[glp_pkg::SAMPLE_W] !== want.trig) begin
						$error("trig_out: expected %b, got %b", want.trig,
							m_tdata[glp_pkg::SAMPLE_W]);
						had_error = 1'b1;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule

/* files.f */
rtl/glp_pkg.sv
rtl/glp_scale.sv
rtl/glp_ram.sv
rtl/glp_loop.sv
rtl/gated_record_loop_player.sv
bench/testbench.sv
